// ===== rtl/core/ethfd_pkg.sv =====
// Types and constants for the Ethernet frame filter and EtherType dispatcher.
`default_nettype none

package ethfd_pkg;

	localparam int MAC_W     = 48;
	localparam int LEN_W     = 16;
	localparam int ETYPE_W   = 16;
	localparam int SLOT_W    = 4;
	localparam int PAYLOAD_W = 11;
	localparam int COUNT_W   = 32;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 120;

	localparam logic [LEN_W-1:0] HEADER_BYTES      = 16'd14;
	localparam logic [LEN_W-1:0] MIN_FRAME_BYTES   = 16'd60;
	localparam logic [LEN_W-1:0] MAX_FRAME_BYTES   = 16'd1514;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_BYTES = 16'd1500;

	localparam logic [7:0]       BCAST_BYTE = 8'hFF;
	localparam logic [MAC_W-1:0] BCAST_MAC  = {6{BCAST_BYTE}};

	typedef enum logic [1:0] {
		OP_FRAME      = 2'd0,
		OP_REGISTER   = 2'd1,
		OP_UNREGISTER = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		VERDICT_DISPATCHED = 3'd0,
		VERDICT_TOO_SHORT  = 3'd1,
		VERDICT_TOO_LONG   = 3'd2,
		VERDICT_ADDR_MISS  = 3'd3,
		VERDICT_NO_HANDLER = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_TABLE_FULL = 2'd1,
		STATUS_NOT_FOUND  = 2'd2
	} status_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   frames_seen;
		logic [MAC_W-1:0]     last_source;
		logic [ETYPE_W-1:0]   frame_type;
		logic [PAYLOAD_W-1:0] payload_length;
		logic [SLOT_W-1:0]    handler_slot;
		status_t              op_status;
		verdict_t             frame_verdict;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ethernet_frame_filter_dispatch.sv =====
// Ethernet receive filter with EtherType dispatch table, one word in and one word out.
// Path from input accept to result accept: input reg, then result reg.
// Throughput: 1 word per cycle while the output is not stalled; the table compare over all entries is combinational.
// Table updates take effect for the word that follows directly.
// Reset: async active low; clears table valid bits, last source, frame count, local MAC.
`default_nettype none

module ethernet_frame_filter_dispatch #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               cfg_wr_en,
	input  wire logic [ethfd_pkg::MAC_W-1:0]        cfg_wr_data,   // station MAC

	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// frame_length[15:0], dst_mac[63:16], src_mac[111:64], eth_type[127:112]
	input  wire logic [ethfd_pkg::IN_TDATA_W-1:0]   s_tdata,
	// op[1:0]
	input  wire logic [1:0]                         s_tuser,

	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// frame_verdict[2:0], op_status[4:3], handler_slot[8:5], payload_length[19:9],
	// frame_type[35:20], last_source[83:36], frames_seen[115:84], zero[119:116]
	output      logic [ethfd_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	// input stage
	logic                            valid_s1;
	ethfd_pkg::op_t                  op_s1;
	logic [ethfd_pkg::LEN_W-1:0]     len_s1;
	logic [ethfd_pkg::MAC_W-1:0]     dst_s1;
	logic [ethfd_pkg::MAC_W-1:0]     src_s1;
	logic [ethfd_pkg::ETYPE_W-1:0]   et_s1;

	// result stage
	logic                            valid_s2;
	ethfd_pkg::result_t              res_s2;

	// state
	logic [ethfd_pkg::MAC_W-1:0]     station_mac_q;
	logic [ethfd_pkg::ETYPE_W-1:0]   slot_type_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]        slot_active_q;
	logic [ethfd_pkg::MAC_W-1:0]     last_source_q;
	logic [ethfd_pkg::COUNT_W-1:0]   frame_counter_q;

	logic                            adv_s1;
	logic                            in_accept;

	// lookup
	logic [TABLE_ENTRIES-1:0]        match;
	logic                            hit;
	logic [IDX_W-1:0]                hit_idx;
	logic                            has_free;
	logic [IDX_W-1:0]                free_idx;

	// step results
	ethfd_pkg::result_t              res_d;
	logic [ethfd_pkg::MAC_W-1:0]     last_source_d;
	logic [ethfd_pkg::COUNT_W-1:0]   frame_counter_d;
	logic [ethfd_pkg::LEN_W-1:0]     payload_full;
	logic                            tbl_wr;
	logic                            tbl_set;
	logic                            tbl_clr;
	logic                            tbl_clr_all;
	logic [IDX_W-1:0]                tbl_idx;

	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {4'b0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= ethfd_pkg::op_t'(s_tuser);
			len_s1 <= s_tdata[15:0];
			dst_s1 <= s_tdata[63:16];
			src_s1 <= s_tdata[111:64];
			et_s1  <= s_tdata[127:112];
		end
		if (adv_s1)
			res_s2 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			station_mac_q <= '0;
		else if (cfg_wr_en)
			station_mac_q <= cfg_wr_data;
	end

	// parallel compare and priority pick, lowest slot wins
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			match[i] = slot_active_q[i] && (slot_type_q[i] == et_s1);
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!slot_active_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		res_d           = '0;
		res_d.frame_verdict = ethfd_pkg::VERDICT_DISPATCHED;
		res_d.op_status     = ethfd_pkg::STATUS_OK;
		last_source_d   = last_source_q;
		frame_counter_d = frame_counter_q;
		payload_full    = len_s1 - ethfd_pkg::HEADER_BYTES;
		tbl_wr          = 1'b0;
		tbl_set         = 1'b0;
		tbl_clr         = 1'b0;
		tbl_clr_all     = 1'b0;
		tbl_idx         = '0;
		case (op_s1)
			ethfd_pkg::OP_FRAME: begin
				frame_counter_d = frame_counter_q + 1'b1;
				if (len_s1 < ethfd_pkg::MIN_FRAME_BYTES) begin
					res_d.frame_verdict = ethfd_pkg::VERDICT_TOO_SHORT;
				end else if (len_s1 > ethfd_pkg::MAX_FRAME_BYTES) begin
					res_d.frame_verdict = ethfd_pkg::VERDICT_TOO_LONG;
				end else if (dst_s1 != station_mac_q && dst_s1 != ethfd_pkg::BCAST_MAC) begin
					res_d.frame_verdict = ethfd_pkg::VERDICT_ADDR_MISS;
				end else if (len_s1 < ethfd_pkg::HEADER_BYTES) begin
					res_d.frame_verdict = ethfd_pkg::VERDICT_TOO_SHORT;
				end else if (payload_full > ethfd_pkg::MAX_PAYLOAD_BYTES) begin
					res_d.frame_verdict = ethfd_pkg::VERDICT_TOO_LONG;
				end else begin
					last_source_d    = src_s1;
					res_d.frame_type = et_s1;
					if (hit) begin
						res_d.handler_slot   = ethfd_pkg::SLOT_W'(hit_idx);
						res_d.payload_length = payload_full[ethfd_pkg::PAYLOAD_W-1:0];
					end else begin
						res_d.frame_verdict = ethfd_pkg::VERDICT_NO_HANDLER;
					end
				end
			end
			ethfd_pkg::OP_REGISTER: begin
				if (hit) begin
					res_d.handler_slot = ethfd_pkg::SLOT_W'(hit_idx);
				end else if (has_free) begin
					tbl_wr             = 1'b1;
					tbl_set            = 1'b1;
					tbl_idx            = free_idx;
					res_d.handler_slot = ethfd_pkg::SLOT_W'(free_idx);
				end else begin
					res_d.op_status = ethfd_pkg::STATUS_TABLE_FULL;
				end
			end
			ethfd_pkg::OP_UNREGISTER: begin
				if (hit) begin
					tbl_clr            = 1'b1;
					tbl_idx            = hit_idx;
					res_d.handler_slot = ethfd_pkg::SLOT_W'(hit_idx);
				end else begin
					res_d.op_status = ethfd_pkg::STATUS_NOT_FOUND;
				end
			end
			ethfd_pkg::OP_CLEAR: begin
				tbl_clr_all = 1'b1;
			end
			default: begin
				tbl_clr_all = 1'b0;
			end
		endcase
		res_d.last_source = last_source_d;
		res_d.frames_seen = frame_counter_d;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tbl_wr)
			slot_type_q[tbl_idx] <= et_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q   <= '0;
			last_source_q   <= '0;
			frame_counter_q <= '0;
		end else if (adv_s1) begin
			last_source_q   <= last_source_d;
			frame_counter_q <= frame_counter_d;
			if (tbl_clr_all)
				slot_active_q <= '0;
			else if (tbl_set)
				slot_active_q[tbl_idx] <= 1'b1;
			else if (tbl_clr)
				slot_active_q[tbl_idx] <= 1'b0;
		end
	end

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == ethfd_pkg::OP_FRAME
		|=> frame_counter_q == $past(frame_counter_q) + 1'b1)
		else $error("frame count did not advance on a frame word");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && op_s1 == ethfd_pkg::OP_FRAME) |=> $stable(frame_counter_q))
		else $error("frame count moved without a frame word");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == ethfd_pkg::OP_CLEAR |=> slot_active_q == '0)
		else $error("table not empty after clear");

	a_status_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.frame_verdict != ethfd_pkg::VERDICT_DISPATCHED
		|-> res_s2.op_status == ethfd_pkg::STATUS_OK)
		else $error("table status reported on a frame word");

endmodule

`default_nettype wire
